// ===== design/reply_frame_checker_defines.svh =====
// assertion macros for the reply frame checker
// used by the top level only, no other dependencies
`ifndef REPLY_FRAME_CHECKER_DEFINES_SVH
`define REPLY_FRAME_CHECKER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define RFC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define RFC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/rfc_pkg.sv =====
// shared types, constants and the crc step for the reply frame checker
// no dependencies
`default_nettype none

package rfc_pkg;

   typedef enum logic [1:0] {
      REQ_START = 2'd0,
      REQ_BYTE  = 2'd1,
      REQ_END   = 2'd2,
      REQ_NONE  = 2'd3
   } req_kind_type;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_SHORT      = 3'd1,
      ST_BAD_HEADER = 3'd2,
      ST_INCOMPLETE = 3'd3,
      ST_CRC        = 3'd4,
      ST_BAD_LEN    = 3'd5,
      ST_TOO_LARGE  = 3'd6,
      ST_ROUTE      = 3'd7
   } status_type;

   localparam logic [7:0] CRC_POLY   = 8'h8C;
   localparam logic [7:0] HDR_FIRST  = 8'hAA;
   localparam logic [7:0] HDR_SECOND = 8'h55;

   // byte positions in a frame: AA 55 len board cmd data... crc
   localparam int POS_HDR_FIRST  = 0;
   localparam int POS_HDR_SECOND = 1;
   localparam int POS_LEN        = 2;
   localparam int POS_BOARD      = 3;
   localparam int POS_CMD        = 4;
   localparam int POS_DATA       = 5;
   localparam int MIN_FRAME      = 6;
   localparam int LEN_OVERHEAD   = 2;

   typedef struct packed {
      logic       start;
      logic       take;
      logic       finish;
   } frame_ctl_type;

   typedef struct packed {
      logic [7:0] length_byte;
      logic       header_good;
      logic       crc_good;
      logic [7:0] seen_board;
      logic [7:0] seen_cmd;
      logic [7:0] want_board;
      logic [7:0] want_cmd;
   } frame_sum_type;

   typedef struct packed {
      status_type status;
      logic [7:0] reply_board;
      logic [7:0] reply_cmd;
      logic [7:0] data_len;
   } grade_type;

   // reflected crc-8, one byte
   function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// ===== design/rfc_frame_state.sv =====
// frame state: byte counter, header and crc tracking, routing bytes, payload memory
// depends on rfc_pkg
`default_nettype none

module rfc_frame_state
   import rfc_pkg::*;
#(
   parameter int MAX_FRAME = 80,
   parameter int MAX_DATA  = 16,
   parameter int CNT_W     = $clog2(MAX_FRAME + 1),
   parameter int IDX_W     = $clog2(MAX_DATA + 1),
   parameter int ADDR_W    = (MAX_DATA > 1) ? $clog2(MAX_DATA) : 1
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire frame_ctl_type      ctl,
   input  wire logic [7:0]         rx_byte,
   input  wire logic [7:0]         exp_board,
   input  wire logic [7:0]         exp_cmd,
   input  wire logic [IDX_W-1:0]   rd_idx,
   output logic      [7:0]         rd_data,
   output logic      [CNT_W-1:0]   byte_count,
   output frame_sum_type           summary
);

   logic [CNT_W-1:0] count_ff, count_in;
   logic [7:0]       crc_ff, crc_in;
   frame_sum_type    sum_ff, sum_in;
   logic [7:0]       rd_data_ff;
   logic [7:0]       mem [MAX_DATA];

   logic [7:0]       pos8;
   logic [7:0]       len_now;
   logic [8:0]       pos9;
   logic [8:0]       len9;
   logic             in_frame;
   logic             wr_en;
   logic [ADDR_W-1:0] wr_addr;

   always_comb begin
      pos8     = 8'(count_ff);
      pos9     = 9'(count_ff);
      in_frame = 8'(count_ff) < 8'(MAX_FRAME);
      len_now  = (pos8 == 8'(POS_LEN)) ? rx_byte : sum_ff.length_byte;
      len9     = 9'(len_now);
      wr_en    = ctl.take && in_frame && (pos8 >= 8'(POS_DATA))
                 && ((pos8 - 8'(POS_DATA)) < 8'(MAX_DATA));
      wr_addr  = ADDR_W'(pos8 - 8'(POS_DATA));
   end

   always_comb begin
      count_in = count_ff;
      crc_in   = crc_ff;
      sum_in   = sum_ff;
      if (ctl.start || ctl.finish) begin
         count_in           = '0;
         crc_in             = '0;
         sum_in.length_byte = '0;
         sum_in.header_good = 1'b0;
         sum_in.crc_good    = 1'b0;
         sum_in.seen_board  = '0;
         sum_in.seen_cmd    = '0;
         if (ctl.start) begin
            sum_in.want_board = exp_board;
            sum_in.want_cmd   = exp_cmd;
         end
      end else if (ctl.take && in_frame) begin
         if (pos8 == 8'(POS_HDR_FIRST)) begin
            sum_in.header_good = (rx_byte == HDR_FIRST);
         end else if (pos8 == 8'(POS_HDR_SECOND)) begin
            sum_in.header_good = sum_ff.header_good && (rx_byte == HDR_SECOND);
         end else if (pos8 == 8'(POS_LEN)) begin
            sum_in.length_byte = rx_byte;
         end else if (pos8 == 8'(POS_BOARD)) begin
            sum_in.seen_board = rx_byte;
         end else if (pos8 == 8'(POS_CMD)) begin
            sum_in.seen_cmd = rx_byte;
         end
         if (pos8 >= 8'(POS_BOARD) && pos9 == len9 + 9'(POS_BOARD)) begin
            sum_in.crc_good = (crc_ff == rx_byte);
         end else if (pos8 < 8'(POS_BOARD) || pos9 <= len9 + 9'(POS_LEN)) begin
            crc_in = crc_step(crc_ff, rx_byte);
         end
         count_in = count_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         crc_ff   <= '0;
         sum_ff   <= '0;
      end else begin
         count_ff <= count_in;
         crc_ff   <= crc_in;
         sum_ff   <= sum_in;
      end
   end

   // payload memory, read data registered with write-first bypass
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= rx_byte;
      end
      if (rd_idx < IDX_W'(MAX_DATA)) begin
         if (wr_en && wr_addr == ADDR_W'(rd_idx)) begin
            rd_data_ff <= rx_byte;
         end else begin
            rd_data_ff <= mem[ADDR_W'(rd_idx)];
         end
      end
   end

   assign rd_data    = rd_data_ff;
   assign byte_count = count_ff;
   assign summary    = sum_ff;

endmodule

`default_nettype wire

// ===== design/rfc_grade.sv =====
// grades a finished frame: status in priority order, routing bytes and data length
// depends on rfc_pkg
`default_nettype none

module rfc_grade
   import rfc_pkg::*;
#(
   parameter int MAX_FRAME = 80,
   parameter int MAX_DATA  = 16,
   parameter int CNT_W     = $clog2(MAX_FRAME + 1)
) (
   input  wire logic [CNT_W-1:0] byte_count,
   input  wire frame_sum_type    summary,
   output grade_type             grade
);

   logic [9:0] count10;
   logic [9:0] need10;
   logic [7:0] dl;

   always_comb begin
      count10 = 10'(byte_count);
      need10  = 10'(summary.length_byte) + 10'(POS_CMD);
      dl      = summary.length_byte - 8'(LEN_OVERHEAD);

      grade.status      = ST_OK;
      grade.reply_board = '0;
      grade.reply_cmd   = '0;
      grade.data_len    = '0;
      if (count10 < 10'(MIN_FRAME)) begin
         grade.status = ST_SHORT;
      end else if (!summary.header_good) begin
         grade.status = ST_BAD_HEADER;
      end else if (count10 < need10) begin
         grade.status = ST_INCOMPLETE;
      end else if (!summary.crc_good) begin
         grade.status = ST_CRC;
      end else begin
         grade.reply_board = summary.seen_board;
         grade.reply_cmd   = summary.seen_cmd;
         if (summary.length_byte < 8'(LEN_OVERHEAD)) begin
            grade.status = ST_BAD_LEN;
         end else begin
            grade.data_len = dl;
            if (dl > 8'(MAX_DATA)) begin
               grade.status = ST_TOO_LARGE;
            end else if (summary.seen_board != summary.want_board
                         || summary.seen_cmd != summary.want_cmd) begin
               grade.status = ST_ROUTE;
            end else begin
               grade.status = ST_OK;
            end
         end
      end
   end

endmodule

`default_nettype wire

// ===== design/reply_frame_checker.sv =====
// Reply frame checker. Start and received-byte items are taken one per clock unless an end
// item holds the input register; such an item passes the input register and reaches the frame
// state in the following cycle, with no result. An end item holds the input register while the
// drain counter walks the payload memory one entry a cycle when the result register is free: an
// ok reply gives data_len data results and then the status result, so the end item gives
// data_len + 1 results (at most MAX_DATA + 1), and any other reply gives one. Each result is
// presented from the result register. No clearing pass follows reset.
// depends on rfc_pkg, rfc_frame_state, rfc_grade and reply_frame_checker_defines.svh
`default_nettype none
`include "reply_frame_checker_defines.svh"

module reply_frame_checker
   import rfc_pkg::*;
#(
   parameter int MAX_FRAME = 80,
   parameter int MAX_DATA  = 16
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [1:0] req_type,
   input  wire logic [7:0] req_rx_byte,
   input  wire logic [7:0] req_expected_board,
   input  wire logic [7:0] req_expected_cmd,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_data_byte,
   output logic [3:0]      rsp_data_index,
   output logic [2:0]      rsp_status,
   output logic [7:0]      rsp_reply_board,
   output logic [7:0]      rsp_reply_cmd,
   output logic [7:0]      rsp_data_len,
   output logic            rsp_last
);

   localparam int CNT_W = $clog2(MAX_FRAME + 1);
   localparam int IDX_W = $clog2(MAX_DATA + 1);

   // input register
   logic         in_valid_ff;
   req_kind_type in_kind_ff;
   logic [7:0]   in_byte_ff;
   logic [7:0]   in_board_ff;
   logic [7:0]   in_cmd_ff;

   // drain counter
   logic [IDX_W-1:0] drain_idx_ff, drain_idx_in;

   // result register
   logic         rsp_valid_ff;
   logic [7:0]   rsp_data_byte_ff;
   logic [3:0]   rsp_data_index_ff;
   status_type   rsp_status_ff;
   logic [7:0]   rsp_reply_board_ff;
   logic [7:0]   rsp_reply_cmd_ff;
   logic [7:0]   rsp_data_len_ff;
   logic         rsp_last_ff;

   frame_ctl_type    ctl;
   frame_sum_type    summary;
   grade_type        grade;
   logic [CNT_W-1:0] byte_count;
   logic [7:0]       rd_data;
   logic [7:0]       drain_ext;

   logic out_free;
   logic end_here;
   logic more_data;
   logic emit_data;
   logic emit_status;
   logic stage_done;

   always_comb begin
      out_free    = !rsp_valid_ff || rsp_ready;
      end_here    = in_valid_ff && (in_kind_ff == REQ_END);
      drain_ext   = 8'(drain_idx_ff);
      more_data   = (grade.status == ST_OK) && (drain_ext < grade.data_len);
      emit_data   = end_here && out_free && more_data;
      emit_status = end_here && out_free && !more_data;
      stage_done  = in_valid_ff && (!end_here || emit_status);
      req_ready   = !in_valid_ff || stage_done;

      ctl.start  = in_valid_ff && (in_kind_ff == REQ_START);
      ctl.take   = in_valid_ff && (in_kind_ff == REQ_BYTE);
      ctl.finish = emit_status;

      drain_idx_in = drain_idx_ff;
      if (emit_status) begin
         drain_idx_in = '0;
      end else if (emit_data) begin
         drain_idx_in = drain_idx_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
      if (req_valid && req_ready) begin
         in_kind_ff  <= req_kind_type'(req_type);
         in_byte_ff  <= req_rx_byte;
         in_board_ff <= req_expected_board;
         in_cmd_ff   <= req_expected_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         drain_idx_ff <= '0;
      end else begin
         drain_idx_ff <= drain_idx_in;
      end
   end

   rfc_frame_state #(
      .MAX_FRAME (MAX_FRAME),
      .MAX_DATA  (MAX_DATA),
      .CNT_W     (CNT_W),
      .IDX_W     (IDX_W)
   ) u_state (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .rx_byte    (in_byte_ff),
      .exp_board  (in_board_ff),
      .exp_cmd    (in_cmd_ff),
      .rd_idx     (drain_idx_in),
      .rd_data    (rd_data),
      .byte_count (byte_count),
      .summary    (summary)
   );

   rfc_grade #(
      .MAX_FRAME (MAX_FRAME),
      .MAX_DATA  (MAX_DATA),
      .CNT_W     (CNT_W)
   ) u_grade (
      .byte_count (byte_count),
      .summary    (summary),
      .grade      (grade)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= emit_data || emit_status;
      end
      if (emit_data) begin
         rsp_data_byte_ff   <= rd_data;
         rsp_data_index_ff  <= drain_ext[3:0];
         rsp_status_ff      <= ST_OK;
         rsp_reply_board_ff <= grade.reply_board;
         rsp_reply_cmd_ff   <= grade.reply_cmd;
         rsp_data_len_ff    <= grade.data_len;
         rsp_last_ff        <= 1'b0;
      end else if (emit_status) begin
         rsp_data_byte_ff   <= '0;
         rsp_data_index_ff  <= '0;
         rsp_status_ff      <= grade.status;
         rsp_reply_board_ff <= grade.reply_board;
         rsp_reply_cmd_ff   <= grade.reply_cmd;
         rsp_data_len_ff    <= grade.data_len;
         rsp_last_ff        <= 1'b1;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data_byte   = rsp_data_byte_ff;
   assign rsp_data_index  = rsp_data_index_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_reply_board = rsp_reply_board_ff;
   assign rsp_reply_cmd   = rsp_reply_cmd_ff;
   assign rsp_data_len    = rsp_data_len_ff;
   assign rsp_last        = rsp_last_ff;

   `RFC_ASSERT_NOW(a_drain_bound, clock, reset, 1'b1,
      drain_idx_ff <= IDX_W'(MAX_DATA), "drain index beyond payload store")
   `RFC_ASSERT_NEXT(a_finish_clears, clock, reset, emit_status,
      byte_count == '0 && drain_idx_ff == '0, "frame state not cleared after status item")
   `RFC_ASSERT_NOW(a_hold_while_drain, clock, reset, end_here && !emit_status,
      !req_ready, "input taken while end item still draining")
   `RFC_ASSERT_NEXT(a_drain_feeds_out, clock, reset, emit_data,
      rsp_valid && !rsp_last && rsp_status == ST_OK, "data item not presented after drain step")

endmodule

`default_nettype wire

// ===== tb/reply_frame_checker_monitor.sv =====
// watches both channels of reply_frame_checker, predicts every result and compares it
// depends on rfc_pkg; hands its failure count and coverage counts to the test top
`default_nettype none

module reply_frame_checker_monitor
   import rfc_pkg::*;
#(
   parameter int MAX_FRAME = 80,
   parameter int MAX_DATA  = 16
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire logic       req_ready,
   input  wire logic [1:0] req_type,
   input  wire logic [7:0] req_rx_byte,
   input  wire logic [7:0] req_expected_board,
   input  wire logic [7:0] req_expected_cmd,
   input  wire logic       rsp_valid,
   input  wire logic       rsp_ready,
   input  wire logic [7:0] rsp_data_byte,
   input  wire logic [3:0] rsp_data_index,
   input  wire logic [2:0] rsp_status,
   input  wire logic [7:0] rsp_reply_board,
   input  wire logic [7:0] rsp_reply_cmd,
   input  wire logic [7:0] rsp_data_len,
   input  wire logic       rsp_last,
   output int              errors,
   output int              pending,
   output int              replies_graded,
   output int              payload_checked,
   output logic [7:0]      status_seen
);

   typedef struct packed {
      logic [7:0] data_byte;
      logic [3:0] data_index;
      status_type status;
      logic [7:0] reply_board;
      logic [7:0] reply_cmd;
      logic [7:0] data_len;
      logic       last;
   } reply_result_type;

   reply_result_type expected_replies[$];

   int         frame_bytes;
   logic [7:0] running_crc;
   logic [7:0] len_byte;
   logic       hdr_ok;
   logic       crc_ok;
   logic [7:0] seen_board;
   logic [7:0] seen_cmd;
   logic [7:0] want_board;
   logic [7:0] want_cmd;
   logic [7:0] payload[MAX_DATA];

   initial begin
      errors = 0;
      replies_graded = 0;
      payload_checked = 0;
      status_seen = '0;
   end

   function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      repeat (8) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   function automatic void clear_frame();
      frame_bytes = 0;
      running_crc = '0;
      len_byte = '0;
      hdr_ok = 1'b0;
      crc_ok = 1'b0;
      seen_board = '0;
      seen_cmd = '0;
      foreach (payload[i]) payload[i] = '0;
   endfunction

   function automatic void absorb_byte(input logic [7:0] b);
      int p;
      int len;
      p = frame_bytes;
      len = len_byte;
      if (p >= MAX_FRAME) return;
      if (p == POS_HDR_FIRST) begin
         hdr_ok = (b == HDR_FIRST);
      end else if (p == POS_HDR_SECOND) begin
         hdr_ok = hdr_ok && (b == HDR_SECOND);
      end else if (p == POS_LEN) begin
         len_byte = b;
         len = b;
      end else if (p == POS_BOARD) begin
         seen_board = b;
      end else if (p == POS_CMD) begin
         seen_cmd = b;
      end else if (p - POS_DATA < MAX_DATA) begin
         payload[p - POS_DATA] = b;
      end
      // crc byte sits right after the covered span
      if (p >= POS_BOARD && p == len + 3) begin
         crc_ok = (running_crc == b);
      end else if (p < POS_BOARD || p <= len + 2) begin
         running_crc = crc8_next(running_crc, b);
      end
      frame_bytes = p + 1;
   endfunction

   function automatic void grade_frame();
      status_type verdict;
      logic [7:0] rb;
      logic [7:0] rc;
      logic [7:0] dl;
      reply_result_type r;
      rb = '0;
      rc = '0;
      dl = '0;
      if (frame_bytes < MIN_FRAME) begin
         verdict = ST_SHORT;
      end else if (!hdr_ok) begin
         verdict = ST_BAD_HEADER;
      end else if (frame_bytes < int'(len_byte) + 4) begin
         verdict = ST_INCOMPLETE;
      end else if (!crc_ok) begin
         verdict = ST_CRC;
      end else begin
         rb = seen_board;
         rc = seen_cmd;
         if (int'(len_byte) < LEN_OVERHEAD) begin
            verdict = ST_BAD_LEN;
         end else begin
            dl = len_byte - 8'(LEN_OVERHEAD);
            if (int'(dl) > MAX_DATA) verdict = ST_TOO_LARGE;
            else if (rb != want_board || rc != want_cmd) verdict = ST_ROUTE;
            else verdict = ST_OK;
         end
      end
      if (verdict == ST_OK) begin
         for (int i = 0; i < int'(dl); i++) begin
            r = '{payload[i], 4'(i), ST_OK, rb, rc, dl, 1'b0};
            expected_replies.push_back(r);
         end
      end
      r = '{8'h00, 4'h0, verdict, rb, rc, dl, 1'b1};
      expected_replies.push_back(r);
      clear_frame();
   endfunction

   function automatic void check_field(input string name, input logic [7:0] want,
                                       input logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         errors++;
      end
   endfunction

   always @(posedge clock) begin
      reply_result_type exp;
      if (reset) begin
         clear_frame();
         want_board = '0;
         want_cmd = '0;
         expected_replies.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (rsp_last === 1'b1) begin
               replies_graded++;
               status_seen[rsp_status] = 1'b1;
            end else begin
               payload_checked++;
            end
            if (expected_replies.size() == 0) begin
               $error("unexpected result: status %0d last %0b", rsp_status, rsp_last);
               errors++;
            end else begin
               exp = expected_replies.pop_front();
               check_field("data_byte", exp.data_byte, rsp_data_byte);
               check_field("data_index", 8'(exp.data_index), 8'(rsp_data_index));
               check_field("status", 8'(exp.status), 8'(rsp_status));
               check_field("reply_board", exp.reply_board, rsp_reply_board);
               check_field("reply_cmd", exp.reply_cmd, rsp_reply_cmd);
               check_field("data_len", exp.data_len, rsp_data_len);
               check_field("last", 8'(exp.last), 8'(rsp_last));
            end
         end
         if (req_valid && req_ready) begin
            case (req_kind_type'(req_type))
               REQ_START: begin
                  clear_frame();
                  want_board = req_expected_board;
                  want_cmd = req_expected_cmd;
               end
               REQ_BYTE: absorb_byte(req_rx_byte);
               REQ_END: grade_frame();
               default: ;
            endcase
         end
      end
      pending <= expected_replies.size();
   end

endmodule

`default_nettype wire

// ===== tb/reply_frame_checker_test.sv =====
// test top for reply_frame_checker: clock, reset, frame stimulus and the verdict
// depends on rfc_pkg, reply_frame_checker and reply_frame_checker_monitor
`default_nettype none

module reply_frame_checker_test;
   import rfc_pkg::*;

   localparam int TOTAL_ITEMS  = 275;
   localparam int HOLD_CYCLES  = 400;
   localparam int STALL_LIMIT  = 2000;
   localparam int TAIL_CYCLES  = 24;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [1:0] req_type = REQ_NONE;
   logic [7:0] req_rx_byte = '0;
   logic [7:0] req_expected_board = '0;
   logic [7:0] req_expected_cmd = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_data_byte;
   logic [3:0] rsp_data_index;
   logic [2:0] rsp_status;
   logic [7:0] rsp_reply_board;
   logic [7:0] rsp_reply_cmd;
   logic [7:0] rsp_data_len;
   logic       rsp_last;

   int         errors;
   int         pending;
   int         replies_graded;
   int         payload_checked;
   logic [7:0] status_seen;

   int         items_sent = 0;
   int         idle_cycles = 0;
   bit         sender_fast = 1'b0;
   bit         hold_req = 1'b0;
   logic [7:0] cur_board = '0;
   logic [7:0] cur_cmd = '0;

   always #6 clock = ~clock;

   reply_frame_checker dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_type(req_type),
      .req_rx_byte(req_rx_byte), .req_expected_board(req_expected_board),
      .req_expected_cmd(req_expected_cmd),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data_byte(rsp_data_byte),
      .rsp_data_index(rsp_data_index), .rsp_status(rsp_status),
      .rsp_reply_board(rsp_reply_board), .rsp_reply_cmd(rsp_reply_cmd),
      .rsp_data_len(rsp_data_len), .rsp_last(rsp_last)
   );

   reply_frame_checker_monitor chk (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_type(req_type),
      .req_rx_byte(req_rx_byte), .req_expected_board(req_expected_board),
      .req_expected_cmd(req_expected_cmd),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data_byte(rsp_data_byte),
      .rsp_data_index(rsp_data_index), .rsp_status(rsp_status),
      .rsp_reply_board(rsp_reply_board), .rsp_reply_cmd(rsp_reply_cmd),
      .rsp_data_len(rsp_data_len), .rsp_last(rsp_last),
      .errors(errors), .pending(pending), .replies_graded(replies_graded),
      .payload_checked(payload_checked), .status_seen(status_seen)
   );

   task automatic send_item(input req_kind_type kind, input logic [7:0] rx,
                            input logic [7:0] board, input logic [7:0] cmd);
      int gap;
      gap = sender_fast ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= kind;
      req_rx_byte <= rx;
      req_expected_board <= board;
      req_expected_cmd <= cmd;
      do @(posedge clock); while (!req_ready);
      if (kind != REQ_NONE) items_sent++;
   endtask

   task automatic send_start(input logic [7:0] board, input logic [7:0] cmd);
      cur_board = board;
      cur_cmd = cmd;
      send_item(REQ_START, 8'($urandom), board, cmd);
   endtask

   task automatic send_end();
      send_item(REQ_END, 8'($urandom), 8'($urandom), 8'($urandom));
   endtask

   // AA 55 len board cmd data... crc, then optional trailing bytes or a cut tail
   task automatic send_frame(input logic [7:0] board, input logic [7:0] cmd,
                             input logic [7:0] len, input bit spoil_hdr,
                             input bit spoil_crc, input int pad, input int cut);
      logic [7:0] body[$];
      logic [7:0] crc;
      for (int p = 0; p <= int'(len) + 2; p++) begin
         case (p)
            POS_HDR_FIRST: body.push_back(HDR_FIRST);
            POS_HDR_SECOND: body.push_back(HDR_SECOND);
            POS_LEN: body.push_back(len);
            POS_BOARD: body.push_back(board);
            POS_CMD: body.push_back(cmd);
            default: body.push_back(8'($urandom));
         endcase
      end
      crc = '0;
      foreach (body[i]) begin
         crc = crc ^ body[i];
         repeat (8) crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
      end
      if (spoil_crc) crc = crc ^ 8'($urandom_range(1, 255));
      body.push_back(crc);
      if (spoil_hdr) body[$urandom_range(0, 1)] ^= 8'(1 << $urandom_range(0, 7));
      repeat (pad) body.push_back(8'($urandom));
      repeat (cut) if (body.size() > 0) void'(body.pop_back());
      foreach (body[i]) send_item(REQ_BYTE, body[i], 8'($urandom), 8'($urandom));
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   // receiver: random stalls, quiet stretches, and one long hold on request
   initial begin
      int gap;
      int quick_left;
      quick_left = 0;
      wait (!reset);
      forever begin
         if (hold_req) begin
            hold_req = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            if (quick_left == 0 && $urandom_range(0, 7) == 0)
               quick_left = $urandom_range(20, 60);
            if (quick_left > 0) begin
               gap = 0;
               quick_left--;
            end else begin
               gap = $urandom_range(0, 13);
            end
            if (gap > 0) begin
               rsp_ready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("no progress for %0d cycles, %0d results outstanding",
                     idle_cycles, pending);
            $display("reply_frame_checker_test: done, errors");
            $finish;
         end
      end
   end

   initial begin
      int r;
      logic [7:0] len;
      logic [7:0] board;
      logic [7:0] cmd;
      logic [7:0] flip;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed frames
      send_end();
      send_start(8'hFF, 8'h00);
      send_frame(8'hFF, 8'h00, 8'd2, 0, 0, 0, 0);
      send_end();
      send_start(8'h00, 8'hFF);
      send_frame(8'h00, 8'hFF, 8'd18, 0, 0, 0, 0);
      send_end();
      send_frame(8'h00, 8'hFF, 8'd19, 0, 0, 0, 0);
      send_end();
      send_frame(8'h00, 8'hFF, 8'd0, 0, 0, 2, 0);
      send_end();
      send_frame(8'h00, 8'hFF, 8'd1, 0, 0, 1, 0);
      send_end();
      send_frame(8'h00, 8'hFF, 8'd4, 1, 0, 0, 0);
      send_end();
      send_frame(8'h00, 8'hFF, 8'd4, 0, 1, 0, 0);
      send_end();
      send_frame(8'h00, 8'hFF, 8'd10, 0, 0, 0, 3);
      send_end();
      send_frame(8'h00, 8'hFF, 8'd5, 0, 0, 0, 6);
      send_end();
      send_frame(8'h01, 8'hFF, 8'd3, 0, 0, 0, 0);
      send_end();
      send_end();
      send_item(REQ_NONE, 8'($urandom), 8'($urandom), 8'($urandom));
      send_frame(8'h00, 8'hFF, 8'd76, 0, 0, 8, 0);
      send_end();
      send_frame(8'h00, 8'hFF, 8'd6, 0, 0, 3, 0);
      send_end();

      // back up the result side until the input stalls, then let it all drain
      sender_fast = 1'b1;
      hold_req = 1'b1;
      repeat (2) begin
         send_frame(cur_board, cur_cmd, 8'd10, 0, 0, 0, 0);
         send_end();
      end
      sender_fast = 1'b0;
      wait_for_drain();

      while (items_sent < TOTAL_ITEMS) begin
         sender_fast = ($urandom_range(0, 4) == 0);
         if ($urandom_range(0, 99) < 75) begin
            if ($urandom_range(0, 2) == 0) send_start(8'($urandom), 8'($urandom));
            r = $urandom_range(0, 19);
            if (r < 13) len = 8'($urandom_range(2, 8));
            else if (r < 15) len = 8'($urandom_range(9, 18));
            else if (r < 17) len = 8'($urandom_range(0, 1));
            else len = 8'($urandom_range(19, 26));
            board = cur_board;
            cmd = cur_cmd;
            if ($urandom_range(0, 7) == 0) begin
               flip = 8'(1 << $urandom_range(0, 7));
               if ($urandom_range(0, 1) == 1) board ^= flip;
               else cmd ^= flip;
            end
            send_frame(board, cmd, len, $urandom_range(0, 11) == 0,
                       $urandom_range(0, 9) == 0,
                       ($urandom_range(0, 5) == 0) ? $urandom_range(1, 4) : 0,
                       ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 0);
            send_end();
         end else begin
            repeat ($urandom_range(1, 6)) begin
               r = $urandom_range(0, 9);
               if (r < 6) send_item(REQ_BYTE, 8'($urandom), 8'($urandom), 8'($urandom));
               else if (r < 8) send_end();
               else if (r < 9) send_item(REQ_NONE, 8'($urandom), 8'($urandom), 8'($urandom));
               else send_start(8'($urandom), 8'($urandom));
            end
         end
         if ($urandom_range(0, 14) == 0) wait_for_drain();
      end
      sender_fast = 1'b0;

      wait_for_drain();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("run covered %0d items, %0d graded replies, %0d payload results",
               items_sent, replies_graded, payload_checked);
      $display("status codes returned (one bit per code, ok at right): %b", status_seen);
      if (errors == 0 && pending == 0) begin
         $display("reply_frame_checker_test: done, clean");
      end else begin
         $display("reply_frame_checker_test: done, errors");
      end
      $finish;
   end

endmodule

`default_nettype wire
